@@ design/servo_slew_rate_positioner_defines.svh @@
// assertion macros shared by the checker
`ifndef SERVO_SLEW_RATE_POSITIONER_DEFINES_SVH
`define SERVO_SLEW_RATE_POSITIONER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define SRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/srp_pkg.sv @@
package srp_pkg;

  localparam int ANGLE_W     = 8;
  localparam int LEVEL_W     = 7;
  localparam int RATE_W      = 16;
  localparam int CMD_W       = 2;
  localparam int ELAP_W      = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int MAG_W       = LEVEL_W + ANGLE_W;   // level * |span|
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int QUO100_W    = 9;
  localparam int SUM_W       = 11;                  // signed level-map result
  localparam int DIV_CNT_W   = $clog2(RATE_W);

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DETACH_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DETACH_TIME   = 3'd5;

  // x / 100 == (x * 5243) >> 19 for every x below 2^15
  localparam logic [RECIP_W-1:0] DIV100_MUL   = 13'd5243;
  localparam int                 DIV100_SHIFT = 19;

  localparam logic [ELAP_W-1:0] ELAPSED_MAX = {ELAP_W{1'b1}};

  typedef struct packed {
    logic [ANGLE_W-1:0] min_angle;
    logic [ANGLE_W-1:0] max_angle;
    logic [ANGLE_W-1:0] start_angle;
    logic [RATE_W-1:0]  initial_rate;
    logic               detach_enable;
    logic [RATE_W-1:0]  detach_time;
  } srp_cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [LEVEL_W-1:0] level;
    logic [RATE_W-1:0]  rate;
    logic [ANGLE_W-1:0] target;
    logic [ANGLE_W-1:0] origin;
  } srp_cmd_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               angle_written;
    logic               drive_on;
    logic               move_active;
    logic               report;
    logic [LEVEL_W-1:0] report_level;
    logic [ANGLE_W-1:0] report_target;
    logic [RATE_W-1:0]  report_rate;
  } srp_res_t;

  function automatic logic [ANGLE_W-1:0] angle_lo(input srp_cfg_t c);
    angle_lo = (c.min_angle < c.max_angle) ? c.min_angle : c.max_angle;
  endfunction

  function automatic logic [ANGLE_W-1:0] angle_hi(input srp_cfg_t c);
    angle_hi = (c.min_angle < c.max_angle) ? c.max_angle : c.min_angle;
  endfunction

  function automatic logic [ANGLE_W-1:0] angle_span(input srp_cfg_t c);
    angle_span = angle_hi(c) - angle_lo(c);
  endfunction

endpackage

@@ design/servo_slew_rate_positioner.sv @@
// servo slew-rate positioner: each input beat is a command (tick of one millisecond, move
// to a level 0..100 at a full-range duration, or init toward the configured start angle) and
// gives exactly one result beat with the present angle, drive and move status, and a
// report on init or on arrival at the target. a move maps its level linearly between
// min_angle and max_angle and clamps it to that span; the angle then steps one degree each
// time more than rate / |max_angle - min_angle| ticks have passed since the last step.
// the front end accepts a command, multiplies it by the reciprocal and pushes it to the
// queue, and takes no new command until that push, which waits while the queue is full;
// a move or init then holds the back end while the step period goes through the 16-step
// divider, during which later commands wait in the 2-entry queue. the result register
// takes a new beat only while it is empty or its waiting result is taken. configuration
// is written through the cfg port; the user must write it while the block is idle, as the block does not enforce it.
module servo_slew_rate_positioner (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [srp_pkg::IN_TDATA_W-1:0]    in_tdata,   // level[6:0], rate[22:7], zero[23]
  input  logic [srp_pkg::CMD_W-1:0]         in_tuser,   // command[1:0]
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // angle[7:0], angle_written[8], drive_on[9], move_active[10], report_level[17:11],
  // report_target[25:18], report_rate[41:26], zero[47:42]
  output logic [srp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,  // report[0]
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  srp_pkg::srp_cfg_t cfg_r;
  srp_pkg::srp_cmd_t q_wdata, q_rdata;
  srp_pkg::srp_res_t res;
  logic              q_push, q_pop, q_full, q_empty;
  logic              res_valid;

  // register file is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_angle     <= 8'd0;
      cfg_r.max_angle     <= 8'd180;
      cfg_r.start_angle   <= 8'd90;
      cfg_r.initial_rate  <= 16'd2000;
      cfg_r.detach_enable <= 1'b0;
      cfg_r.detach_time   <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srp_pkg::REG_MIN_ANGLE:     cfg_r.min_angle     <= cfg_data[srp_pkg::ANGLE_W-1:0];
        srp_pkg::REG_MAX_ANGLE:     cfg_r.max_angle     <= cfg_data[srp_pkg::ANGLE_W-1:0];
        srp_pkg::REG_START_ANGLE:   cfg_r.start_angle   <= cfg_data[srp_pkg::ANGLE_W-1:0];
        srp_pkg::REG_INITIAL_RATE:  cfg_r.initial_rate  <= cfg_data;
        srp_pkg::REG_DETACH_ENABLE: cfg_r.detach_enable <= cfg_data[0];
        srp_pkg::REG_DETACH_TIME:   cfg_r.detach_time   <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // front end: decode the command and work out the clamped target
  srp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_level (in_tdata[6:0]),
    .in_rate  (in_tdata[22:7]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // decoded commands wait here so front and back stall independently
  srp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back end: slew state, tick timing, detach timer, step period divide
  srp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (out_tready),
    .res       (res)
  );

  // result beat packing, lowest field first
  assign out_tvalid = res_valid;
  assign out_tuser  = res.report;
  assign out_tdata  = {6'b000000, res.report_rate, res.report_target, res.report_level,
                       res.move_active, res.drive_on, res.angle_written, res.angle};

endmodule

@@ design/srp_front.sv @@
module srp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  srp_pkg::srp_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srp_pkg::CMD_W-1:0]    in_cmd,
  input  logic [srp_pkg::LEVEL_W-1:0]  in_level,
  input  logic [srp_pkg::RATE_W-1:0]   in_rate,
  input  logic                         q_full,
  output logic                         q_push,
  output srp_pkg::srp_cmd_t            q_wdata
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]                    fstate_r, fstate_nxt;
  logic [srp_pkg::CMD_W-1:0]     cmd_r;
  logic [srp_pkg::LEVEL_W-1:0]   lvl_r;
  logic [srp_pkg::RATE_W-1:0]    rate_r;
  logic                          neg_r;
  logic [srp_pkg::MAG_W-1:0]     mag_r;
  logic [srp_pkg::PROD_W-1:0]    prod_r;

  logic                          accept;
  logic [srp_pkg::QUO100_W-1:0]  quo;
  logic signed [srp_pkg::SUM_W-1:0] t_map, t_start, lo_s, hi_s, t_sel;
  logic [srp_pkg::ANGLE_W-1:0]   lo, hi, tgt;
  logic [srp_pkg::ANGLE_W:0]     end_sum;

  assign in_ready = (fstate_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    fstate_nxt = fstate_r;
    q_push     = 1'b0;
    case (fstate_r)
      F_IDLE: if (accept) fstate_nxt = F_MUL;
      F_MUL:  fstate_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          fstate_nxt = F_IDLE;
        end
      end
      default: fstate_nxt = F_IDLE;
    endcase
  end

  // level map: min + sign * (level * |max - min|) / 100, truncated toward zero
  always_comb begin
    lo      = srp_pkg::angle_lo(cfg);
    hi      = srp_pkg::angle_hi(cfg);
    lo_s    = $signed({3'b000, lo});
    hi_s    = $signed({3'b000, hi});
    quo     = prod_r[srp_pkg::DIV100_SHIFT +: srp_pkg::QUO100_W];
    t_map   = $signed({3'b000, cfg.min_angle}) +
              (neg_r ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));
    t_start = $signed({3'b000, cfg.start_angle});
    t_sel   = (cmd_r == srp_pkg::CMD_INIT) ? t_start : t_map;
    if (t_sel < lo_s)      tgt = lo;
    else if (t_sel > hi_s) tgt = hi;
    else                   tgt = t_sel[srp_pkg::ANGLE_W-1:0];
    end_sum = {1'b0, cfg.min_angle} + {1'b0, cfg.max_angle};

    q_wdata.cmd    = cmd_r;
    q_wdata.level  = lvl_r;
    q_wdata.rate   = (cmd_r == srp_pkg::CMD_INIT) ? cfg.initial_rate : rate_r;
    q_wdata.target = tgt;
    q_wdata.origin = end_sum[srp_pkg::ANGLE_W:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
    end else begin
      fstate_r <= fstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      lvl_r  <= in_level;
      rate_r <= in_rate;
      neg_r  <= (cfg.max_angle < cfg.min_angle);
      mag_r  <= srp_pkg::MAG_W'(in_level * srp_pkg::angle_span(cfg));
    end
    if (fstate_r == F_MUL) begin
      prod_r <= srp_pkg::PROD_W'(mag_r * srp_pkg::DIV100_MUL);
    end
  end

endmodule

@@ design/srp_queue.sv @@
module srp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srp_pkg::srp_cmd_t wdata,
  input  logic              pop,
  output srp_pkg::srp_cmd_t rdata,
  output logic              full,
  output logic              empty
);

  // two-slot shift queue, head always at slot 0
  logic [1:0]        cnt_r, cnt_nxt;
  srp_pkg::srp_cmd_t head_r, tail_r;

  assign rdata = head_r;
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    case (cnt_r)
      2'd0:    if (push) cnt_nxt = 2'd1;
      2'd1:    if (push && !pop) cnt_nxt = 2'd2;
               else if (pop && !push) cnt_nxt = 2'd0;
      2'd2:    if (pop) cnt_nxt = 2'd1;
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cnt_r)
      2'd0:    if (push) head_r <= wdata;
      2'd1: begin
        if (push && pop) head_r <= wdata;
        else if (push)   tail_r <= wdata;
      end
      2'd2:    if (pop) head_r <= tail_r;
      default: ;
    endcase
  end

endmodule

@@ design/srp_div.sv @@
module srp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [srp_pkg::RATE_W-1:0]  dividend,
  input  logic [srp_pkg::ANGLE_W-1:0] divisor,
  output logic                        done,
  output logic [srp_pkg::RATE_W-1:0]  quotient
);

  // restoring divider, one quotient bit per cycle
  logic                           busy_r, done_r;
  logic [srp_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [srp_pkg::RATE_W-1:0]     quo_r;
  logic [srp_pkg::ANGLE_W-1:0]    rem_r, dvs_r;
  logic [srp_pkg::ANGLE_W:0]      sh;
  logic                           qbit;
  logic [srp_pkg::ANGLE_W:0]      diff;

  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    sh   = {rem_r, quo_r[srp_pkg::RATE_W-1]};
    qbit = (sh >= {1'b0, dvs_r});
    diff = sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {srp_pkg::DIV_CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[srp_pkg::RATE_W-2:0], qbit};
      rem_r <= qbit ? diff[srp_pkg::ANGLE_W-1:0] : sh[srp_pkg::ANGLE_W-1:0];
    end
  end

endmodule

@@ design/srp_back.sv @@
module srp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  srp_pkg::srp_cfg_t cfg,
  input  logic              q_empty,
  input  srp_pkg::srp_cmd_t q_rdata,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output srp_pkg::srp_res_t res
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_DIV  = 1'b1;

  logic                          bstate_r, bstate_nxt;
  logic [srp_pkg::ANGLE_W-1:0]   cur_r, cur_nxt, org_r, org_nxt, tgt_r, tgt_nxt;
  logic [srp_pkg::RATE_W-1:0]    crate_r, crate_nxt, period_r, period_nxt;
  logic [srp_pkg::ELAP_W-1:0]    elap_r, elap_nxt;
  logic [srp_pkg::LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic                          moving_r, moving_nxt, detp_r, detp_nxt, att_r, att_nxt;
  logic                          span_zero_r, span_zero_nxt;
  logic                          out_valid_r, out_valid_nxt;
  srp_pkg::srp_res_t             out_r, out_nxt;

  logic                          slot_free, div_start, div_done;
  logic [srp_pkg::RATE_W-1:0]    div_quo;
  logic [srp_pkg::ANGLE_W-1:0]   span;
  logic [srp_pkg::ELAP_W-1:0]    e_inc;
  logic                          fire, step, arrive, drop, written, report;

  assign slot_free = !out_valid_r || res_ready;
  assign q_pop     = (bstate_r == B_IDLE) && !q_empty && slot_free;
  assign span      = srp_pkg::angle_span(cfg);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    bstate_nxt    = bstate_r;
    cur_nxt       = cur_r;
    org_nxt       = org_r;
    tgt_nxt       = tgt_r;
    crate_nxt     = crate_r;
    period_nxt    = period_r;
    elap_nxt      = elap_r;
    lvl_nxt       = lvl_r;
    moving_nxt    = moving_r;
    detp_nxt      = detp_r;
    att_nxt       = att_r;
    span_zero_nxt = span_zero_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    div_start     = 1'b0;
    written       = 1'b0;
    report        = 1'b0;
    e_inc         = (elap_r != srp_pkg::ELAPSED_MAX) ? elap_r + 1'b1 : elap_r;
    fire          = moving_r && (e_inc > {1'b0, period_r});
    step          = fire && (cur_r != tgt_r);
    arrive        = fire && (cur_r == tgt_r);
    drop          = 1'b0;

    if (bstate_r == B_DIV) begin
      if (div_done) begin
        period_nxt = span_zero_r ? '0 : div_quo;
        bstate_nxt = B_IDLE;
      end
    end else if (q_pop) begin
      case (q_rdata.cmd)
        srp_pkg::CMD_TICK: begin
          elap_nxt = fire ? '0 : e_inc;
          if (step) begin
            cur_nxt = (tgt_r >= org_r) ? cur_r + 1'b1 : cur_r - 1'b1;
            written = 1'b1;
          end
          if (arrive) begin
            moving_nxt = 1'b0;
            report     = 1'b1;
            if (cfg.detach_enable) detp_nxt = 1'b1;
          end
          drop = detp_nxt && (elap_nxt > {1'b0, cfg.detach_time});
          if (drop) begin
            detp_nxt = 1'b0;
            att_nxt  = 1'b0;
          end
        end
        srp_pkg::CMD_MOVE, srp_pkg::CMD_INIT: begin
          if (q_rdata.cmd == srp_pkg::CMD_MOVE) begin
            lvl_nxt = q_rdata.level;
            org_nxt = cur_r;
          end else begin
            org_nxt = q_rdata.origin;
            cur_nxt = q_rdata.origin;
            report  = 1'b1;
          end
          tgt_nxt       = q_rdata.target;
          crate_nxt     = q_rdata.rate;
          att_nxt       = 1'b1;
          detp_nxt      = 1'b0;
          moving_nxt    = 1'b1;
          span_zero_nxt = (span == '0);
          div_start     = 1'b1;
          bstate_nxt    = B_DIV;
        end
        default: ;
      endcase

      out_valid_nxt         = 1'b1;
      out_nxt.angle         = cur_nxt;
      out_nxt.angle_written = written;
      out_nxt.drive_on      = att_nxt;
      out_nxt.move_active   = moving_nxt;
      out_nxt.report        = report;
      out_nxt.report_level  = report ? lvl_nxt : '0;
      out_nxt.report_target = report ? tgt_nxt : '0;
      out_nxt.report_rate   = report ? crate_nxt : '0;
    end
  end

  srp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_rdata.rate),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      cur_r       <= '0;
      org_r       <= '0;
      tgt_r       <= '0;
      crate_r     <= '0;
      period_r    <= '0;
      elap_r      <= '0;
      lvl_r       <= '0;
      moving_r    <= 1'b0;
      detp_r      <= 1'b0;
      att_r       <= 1'b0;
      span_zero_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r    <= bstate_nxt;
      cur_r       <= cur_nxt;
      org_r       <= org_nxt;
      tgt_r       <= tgt_nxt;
      crate_r     <= crate_nxt;
      period_r    <= period_nxt;
      elap_r      <= elap_nxt;
      lvl_r       <= lvl_nxt;
      moving_r    <= moving_nxt;
      detp_r      <= detp_nxt;
      att_r       <= att_nxt;
      span_zero_r <= span_zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

@@ design/srp_checker.sv @@
`include "servo_slew_rate_positioner_defines.svh"

module srp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [srp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // a stalled result beat stays put
  `SRP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // report fields are zero without a report
  `SRP_ASSERT_NOW(a_report_zero, out_tvalid && !out_tuser, out_tdata[41:11] == 31'd0, "report fields set without report")

  // a step only happens during a move
  `SRP_ASSERT_NOW(a_step_moving, out_tvalid && out_tdata[8], out_tdata[10], "angle stepped with no move active")

  // a move in progress always has drive
  `SRP_ASSERT_NOW(a_move_drive, out_tvalid && out_tdata[10], out_tdata[9], "move active with drive dropped")

endmodule

bind servo_slew_rate_positioner srp_checker u_srp_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // command code with no meaning: the block only shows its status
  localparam logic [srp_pkg::CMD_W-1:0]     CMD_NONE     = 2'd3;
  // register indexes past the end of the map, writes must be ignored
  localparam logic [srp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [srp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 4000;   // cycles with no beat on any channel
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 135;
  localparam int SEQ_TICK_CAP   = 60;     // ticks after one move at most
  localparam int SETTLE_CYCLES  = 40;     // tail after the last result
  localparam int IDLE_TICKS     = 30;     // back-to-back ticks after arrival

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [srp_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [srp_pkg::CMD_W-1:0]       in_tuser   = srp_pkg::CMD_TICK;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [srp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [srp_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  servo_slew_rate_positioner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // servo state as the testbench sees it
  // ---------------------------------------------------------------------------
  srp_pkg::srp_cfg_t           regs;
  logic [srp_pkg::ANGLE_W-1:0] angle_now, slew_origin, slew_target;
  logic [srp_pkg::RATE_W-1:0]  rate_now, step_ticks;
  logic [srp_pkg::ELAP_W-1:0]  ms_count;
  logic [srp_pkg::LEVEL_W-1:0] level_now;
  logic                        slewing, detach_armed, drive_attached;

  srp_pkg::srp_res_t servo_status_q[$];   // status beats still owed by the block

  // run bookkeeping
  int  mismatches      = 0;
  int  commands_sent   = 0;
  int  results_checked = 0;
  int  settings_used   = 0;
  int  steps_seen      = 0;
  int  reports_seen    = 0;
  int  drops_seen      = 0;
  int  burst_left      = 0;
  int  idle_cycles     = 0;
  bit  full_speed      = 1'b0;   // no sender gaps, no receiver stalls

  // clamp the target into the end-angle span and set off from the origin
  task automatic start_slew();
    logic [srp_pkg::ANGLE_W-1:0] lo, hi, span;
    lo = (regs.min_angle < regs.max_angle) ? regs.min_angle : regs.max_angle;
    hi = (regs.min_angle < regs.max_angle) ? regs.max_angle : regs.min_angle;
    span = hi - lo;
    if (slew_target < lo) slew_target = lo;
    if (slew_target > hi) slew_target = hi;
    step_ticks = (span == 0) ? '0 : rate_now / span;
    angle_now = slew_origin;
    drive_attached = 1'b1;
    detach_armed = 1'b0;
    slewing = 1'b1;
  endtask

  // apply one accepted command and queue the status beat it must produce
  task automatic advance_servo(input logic [srp_pkg::CMD_W-1:0] cmd,
                               input logic [srp_pkg::LEVEL_W-1:0] lvl,
                               input logic [srp_pkg::RATE_W-1:0] rt);
    srp_pkg::srp_res_t         res;
    logic                      stepped, reported;
    logic [srp_pkg::ANGLE_W:0] mid;
    int                        span_signed, mapped;
    stepped = 1'b0;
    reported = 1'b0;
    case (cmd)
      srp_pkg::CMD_TICK: begin
        if (ms_count != srp_pkg::ELAPSED_MAX) ms_count = ms_count + 1'b1;
        if (slewing && ms_count > step_ticks) begin
          ms_count = '0;
          if (angle_now != slew_target) begin
            // direction follows where the move started, not where it is now
            if (slew_target >= slew_origin) angle_now = angle_now + 1'b1;
            else angle_now = angle_now - 1'b1;
            stepped = 1'b1;
          end else begin
            slewing = 1'b0;
            if (regs.detach_enable) detach_armed = 1'b1;
            reported = 1'b1;
          end
        end
        // detach looks at the counter after the step logic on the same tick
        if (detach_armed && ms_count > regs.detach_time) begin
          detach_armed = 1'b0;
          drive_attached = 1'b0;
          drops_seen++;
        end
      end
      srp_pkg::CMD_MOVE: begin
        // signed linear map, division truncates toward zero
        span_signed = int'(regs.max_angle) - int'(regs.min_angle);
        mapped = (int'(lvl) * span_signed) / 100 + int'(regs.min_angle);
        if (mapped < 0) mapped = 0;
        if (mapped > 255) mapped = 255;
        level_now = lvl;
        rate_now = rt;
        slew_origin = angle_now;
        slew_target = srp_pkg::ANGLE_W'(mapped);
        start_slew();
      end
      srp_pkg::CMD_INIT: begin
        mid = {1'b0, regs.min_angle} + {1'b0, regs.max_angle};
        slew_target = regs.start_angle;
        rate_now = regs.initial_rate;
        slew_origin = mid[srp_pkg::ANGLE_W:1];
        start_slew();
        reported = 1'b1;
      end
      default: ;
    endcase
    res.angle = angle_now;
    res.angle_written = stepped;
    res.drive_on = drive_attached;
    res.move_active = slewing;
    res.report = reported;
    res.report_level = reported ? level_now : '0;
    res.report_target = reported ? slew_target : '0;
    res.report_rate = reported ? rate_now : '0;
    servo_status_q.push_back(res);
    commands_sent++;
    if (stepped) steps_seen++;
    if (reported) reports_seen++;
  endtask

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // one command beat, sent in bursts with random gaps between them
  task automatic send_command(input logic [srp_pkg::CMD_W-1:0] cmd,
                              input logic [srp_pkg::LEVEL_W-1:0] lvl,
                              input logic [srp_pkg::RATE_W-1:0] rt);
    int gap;
    @(negedge clk);
    if (!full_speed && burst_left == 0) begin
      in_tvalid <= 1'b0;
      // mostly short gaps, now and then a longer one that can outlast a divider pass
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 25) : $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, rt, lvl};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    advance_servo(cmd, lvl, rt);
  endtask

  // stop offering commands and wait for every owed status beat
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (servo_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [srp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [srp_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    // only the low bits of the angle and detach-enable registers are kept
    case (idx)
      srp_pkg::REG_MIN_ANGLE:     regs.min_angle     = value[srp_pkg::ANGLE_W-1:0];
      srp_pkg::REG_MAX_ANGLE:     regs.max_angle     = value[srp_pkg::ANGLE_W-1:0];
      srp_pkg::REG_START_ANGLE:   regs.start_angle   = value[srp_pkg::ANGLE_W-1:0];
      srp_pkg::REG_INITIAL_RATE:  regs.initial_rate  = value[srp_pkg::RATE_W-1:0];
      srp_pkg::REG_DETACH_ENABLE: regs.detach_enable = value[0];
      srp_pkg::REG_DETACH_TIME:   regs.detach_time   = value[srp_pkg::RATE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // full register set, junk in the unused upper bits, sometimes a spare index
  task automatic program_registers(input logic [srp_pkg::ANGLE_W-1:0] min_v,
                                   input logic [srp_pkg::ANGLE_W-1:0] max_v,
                                   input logic [srp_pkg::ANGLE_W-1:0] start_v,
                                   input logic [srp_pkg::RATE_W-1:0] irate,
                                   input logic den,
                                   input logic [srp_pkg::RATE_W-1:0] dtime);
    if ($urandom_range(0, 1) == 0)
      write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
    write_register(srp_pkg::REG_MIN_ANGLE,     {8'($urandom), min_v});
    write_register(srp_pkg::REG_MAX_ANGLE,     {8'($urandom), max_v});
    write_register(srp_pkg::REG_START_ANGLE,   {8'($urandom), start_v});
    write_register(srp_pkg::REG_INITIAL_RATE,  irate);
    write_register(srp_pkg::REG_DETACH_ENABLE, {15'($urandom), den});
    write_register(srp_pkg::REG_DETACH_TIME,   dtime);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern, checker, watchdog
  // ---------------------------------------------------------------------------

  // rotating ready mask, reloaded now and then: free flow, long stalls or mixed
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_left  = 0;

  always @(negedge clk) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'h8001;
        default: ready_pattern = 16'($urandom) | 16'h0101;
      endcase
      pattern_left = $urandom_range(16, 96);
    end else begin
      pattern_left--;
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
    out_tready <= full_speed || ready_pattern[0];
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // each status beat against the oldest one owed
  always @(posedge clk) begin
    srp_pkg::srp_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (servo_status_q.size() == 0) begin
        $error("status beat with no command outstanding");
        mismatches++;
      end else begin
        want = servo_status_q.pop_front();
        check_field("angle",         want.angle,         out_tdata[7:0]);
        check_field("angle_written", want.angle_written, out_tdata[8]);
        check_field("drive_on",      want.drive_on,      out_tdata[9]);
        check_field("move_active",   want.move_active,   out_tdata[10]);
        check_field("report_level",  want.report_level,  out_tdata[17:11]);
        check_field("report_target", want.report_target, out_tdata[25:18]);
        check_field("report_rate",   want.report_rate,   out_tdata[41:26]);
        check_field("tdata padding", '0,                 out_tdata[47:42]);
        check_field("report",        want.report,        out_tuser);
      end
    end
  end

  // any beat on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d status beats outstanding",
               idle_cycles, servo_status_q.size());
      $display("servo_slew_rate_positioner: mismatch");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: status before anything, init, move above 100
  task automatic test_reset_status();
    send_command(CMD_NONE, 7'h7F, 16'hFFFF);
    send_command(srp_pkg::CMD_TICK, '0, '0);
    send_command(srp_pkg::CMD_INIT, 7'd55, 16'd1234);     // init ignores level and rate
    send_command(srp_pkg::CMD_MOVE, 7'd127, 16'hFFFF);    // extrapolated, then clamped
    send_command(srp_pkg::CMD_TICK, 7'h7F, 16'hFFFF);
    send_command(CMD_NONE, '0, '0);
  endtask

  // min above max, target clamped, downward steps, instant detach
  task automatic test_reversed_span();
    wait_drained();
    program_registers(8'd100, 8'd97, 8'd180, 16'hFFFF, 1'b1, 16'd0);
    send_command(srp_pkg::CMD_INIT, '0, '0);              // start angle clamps to 100
    send_command(srp_pkg::CMD_MOVE, 7'd0, 16'd0);         // period 0
    repeat (4) send_command(srp_pkg::CMD_TICK, '0, '0);   // two steps, arrival, drop
    send_command(srp_pkg::CMD_MOVE, 7'd100, 16'd7);       // downward toward 97
    repeat (5) send_command(srp_pkg::CMD_TICK, '0, '0);
    send_command(srp_pkg::CMD_MOVE, 7'd34, 16'hFFFF);     // -1.02 truncates to -1
    send_command(srp_pkg::CMD_MOVE, 7'd33, 16'd0);        // -0.99 truncates to 0
    repeat (2) send_command(srp_pkg::CMD_TICK, '0, '0);
  endtask

  // zero span: period 0, the first tick after a move already reports arrival
  task automatic test_equal_ends();
    wait_drained();
    program_registers(8'd0, 8'd0, 8'd180, 16'd0, 1'b0, 16'hFFFF);
    send_command(srp_pkg::CMD_INIT, '0, '0);
    send_command(srp_pkg::CMD_MOVE, 7'd127, 16'hFFFF);
    repeat (2) send_command(srp_pkg::CMD_TICK, '0, '0);
  endtask

  // random register sets; mostly a move or init followed by enough ticks
  // to finish it (and often to detach), the rest random commands
  task automatic test_random_phases();
    int                          a, b, swap_v, span, gap_deg, ticks, sent;
    logic [srp_pkg::LEVEL_W-1:0] lvl;
    logic [srp_pkg::RATE_W-1:0]  rt, irate, dtime;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      a = $urandom_range(0, 180);
      b = a + $urandom_range(0, 8);
      if (b > 180) b = 180;
      if ($urandom_range(0, 1)) begin
        swap_v = a;
        a = b;
        b = swap_v;
      end
      irate = 16'($urandom_range(0, 200));
      dtime = 16'($urandom_range(0, 20));
      if (phase == 0) begin
        a = 180;
        b = 0;
        irate = 16'hFFFF;
        dtime = '0;
      end else if (phase == 1) begin
        a = 0;
        b = 180;
        irate = '0;
      end
      program_registers(srp_pkg::ANGLE_W'(a), srp_pkg::ANGLE_W'(b),
                        8'($urandom_range(0, 180)), irate,
                        $urandom_range(0, 3) != 0, dtime);
      span = (a > b) ? a - b : b - a;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 4) == 0) begin
            send_command(srp_pkg::CMD_INIT, 7'($urandom), 16'($urandom));
          end else begin
            lvl = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(101, 127))
                                              : 7'($urandom_range(0, 100));
            case ($urandom_range(0, 7))
              0:       rt = 16'($urandom);
              1:       rt = 16'hFFFF;
              default: rt = 16'($urandom_range(0, 6 * span + 6));
            endcase
            send_command(srp_pkg::CMD_MOVE, lvl, rt);
          end
          // enough ticks to arrive, then to detach; sometimes cut short
          gap_deg = (slew_target > angle_now) ? slew_target - angle_now
                                              : angle_now - slew_target;
          ticks = (gap_deg + 1) * (int'(step_ticks) + 1) + 1 + $urandom_range(0, 3);
          if (regs.detach_enable) ticks += int'(regs.detach_time) + 2;
          if ($urandom_range(0, 5) == 0) ticks = $urandom_range(0, ticks);
          if (ticks > SEQ_TICK_CAP) ticks = SEQ_TICK_CAP;
          repeat (ticks) send_command(srp_pkg::CMD_TICK, 7'($urandom), 16'($urandom));
          sent += ticks + 1;
        end else begin
          send_command(2'($urandom_range(0, 3)), 7'($urandom), 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  // idle stretch after arrival, ticks back to back with no stalls: the drive
  // drops once the detach time has passed and the next move starts from there
  task automatic test_detach_idle();
    wait_drained();
    program_registers(8'd10, 8'd12, 8'd12, 16'd0, 1'b1, 16'd20);
    send_command(srp_pkg::CMD_INIT, '0, '0);
    repeat (4) send_command(srp_pkg::CMD_TICK, '0, '0);
    full_speed = 1'b1;
    repeat (IDLE_TICKS) send_command(srp_pkg::CMD_TICK, 7'($urandom), 16'($urandom));
    full_speed = 1'b0;
    send_command(srp_pkg::CMD_MOVE, 7'd0, 16'd5);
    repeat (4) send_command(srp_pkg::CMD_TICK, '0, '0);
  endtask

  initial begin
    regs = '{min_angle: 8'd0, max_angle: 8'd180, start_angle: 8'd90,
             initial_rate: 16'd2000, detach_enable: 1'b0, detach_time: 16'd1000};
    angle_now = '0;
    slew_origin = '0;
    slew_target = '0;
    rate_now = '0;
    step_ticks = '0;
    ms_count = '0;
    level_now = '0;
    slewing = 1'b0;
    detach_armed = 1'b0;
    drive_attached = 1'b0;

    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_status();
    test_reversed_span();
    test_equal_ends();
    test_random_phases();
    test_detach_idle();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d commands over %0d register sets: %0d angle steps, %0d reports, %0d drops",
             commands_sent, settings_used, steps_seen, reports_seen, drops_seen);
    $display("%0d status beats compared field by field, including a run of ticks at full rate",
             results_checked);
    if (mismatches == 0) begin
      $display("servo_slew_rate_positioner: match");
    end else begin
      $display("servo_slew_rate_positioner: mismatch");
    end
    $finish;
  end

endmodule
